### rtl/weq_pkg.sv
// shared types, constants and arithmetic helpers for the wave grid block
package weq_pkg;

  localparam int GRID_ROWS_DEF = 128;
  localparam int GRID_COLS_DEF = 128;

  localparam logic signed [15:0] COEF_PREV_RST  = -16'sd16286;
  localparam logic signed [15:0] COEF_CURR_RST  = 16'sd31729;
  localparam logic signed [15:0] COEF_NEIGH_RST = 16'sd235;
  localparam logic [19:0]        STEP_PERIOD_RST = 20'd30000;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_DISTURB = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic [1:0] REG_COEF_PREV   = 2'd0;
  localparam logic [1:0] REG_COEF_CURR   = 2'd1;
  localparam logic [1:0] REG_COEF_NEIGH  = 2'd2;
  localparam logic [1:0] REG_STEP_PERIOD = 2'd3;

  typedef struct packed {
    logic signed [15:0] coef_prev;
    logic signed [15:0] coef_curr;
    logic signed [15:0] coef_neigh;
  } coef_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

### rtl/wave_equation_grid_step.sv
// top level of the damped wave equation grid engine
//  channel | dir | payload
//  in_     | in  | tdata: delta_time, row, col, magnitude; tuser: mode
//  out_    | out | tdata: height; tuser: stepped, range_error
//  cfg_    | in  | index 2 bits, data 20 bits
// reset sweep writes zero into both banks, no word accepted meanwhile
// a stepping tick streams the current bank once, one cell per cycle
// through the single bank read port
// a stalled result holds the block; the next word waits until out is taken
module wave_equation_grid_step #(
  parameter int GRID_ROWS = weq_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = weq_pkg::GRID_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // delta_time[15:0], row[22:16], col[29:23], magnitude[45:30]
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // height
  output logic [1:0]  out_tuser,  // stepped, range_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 2*GRID_COLS + 8);
  localparam int RW    = $clog2(GRID_ROWS + 1);
  localparam int CLW   = $clog2(GRID_COLS);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_DIST, S_STEP, S_OUT} state_t;

  state_t             state_r;
  weq_pkg::coef_t     coef_r;
  logic [19:0]        period_r;
  logic [20:0]        accum_r;
  logic               sel_r;
  logic [CW-1:0]      cnt_r;
  logic [6:0]         row_r, col_r;
  logic signed [15:0] mag_r;
  logic [15:0]        height_r;
  logic               stepped_r, rerr_r;

  logic [AW-1:0]      rd_addr;
  logic signed [15:0] rd0, rd1;
  logic               we0, we1;
  logic [AW-1:0]      wa;
  logic signed [15:0] wd;
  logic signed [15:0] rd_cur, rd_prv;

  weq_bank #(.DEPTH(CELLS), .AW(AW)) u_bank0 (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd0),
    .wr_en(we0), .wr_addr(wa), .wr_data(wd));
  weq_bank #(.DEPTH(CELLS), .AW(AW)) u_bank1 (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd1),
    .wr_en(we1), .wr_addr(wa), .wr_data(wd));

  assign rd_cur = sel_r ? rd1 : rd0;
  assign rd_prv = sel_r ? rd0 : rd1;

  // neighbor line: streamed current values, two rows plus a cell deep
  localparam int TAPS = 2*GRID_COLS + 1;
  logic signed [15:0] tap_r [TAPS];
  logic signed [15:0] prvd_r [GRID_COLS+1];
  logic               tapv_r;
  logic [CW-1:0]      rcnt_r;

  // center cell index of the tap line: rcnt - COLS - 1 where rcnt counts values taken
  // crow_r/ccol_r follow the center position once it is inside the grid
  logic [CW-1:0]      ctr;
  logic [AW-1:0]      ctr_a;
  logic [RW-1:0]      crow_r;
  logic [CLW-1:0]     ccol_r;
  logic               interior;
  assign ctr   = rcnt_r - CW'(GRID_COLS + 1);
  assign ctr_a = ctr[AW-1:0];
  assign interior = (rcnt_r >= CW'(2*GRID_COLS + 1)) &&
                    crow_r < RW'(GRID_ROWS-1) && ccol_r != '0 &&
                    ccol_r != CLW'(GRID_COLS-1);

  logic               mac_v;
  logic signed [15:0] mac_h;
  logic [AW-1:0]      wa_q [2];
  logic signed [17:0] nsum;
  assign nsum = 18'(tap_r[0]) + 18'(tap_r[2*GRID_COLS]) +
                18'(tap_r[GRID_COLS-1]) + 18'(tap_r[GRID_COLS+1]);

  weq_mac u_mac (
    .clk(clk), .rst_n(rst_n), .in_valid(tapv_r && interior && state_r == S_STEP),
    .coef(coef_r), .prev_h(prvd_r[GRID_COLS]), .curr_h(tap_r[GRID_COLS]),
    .nsum(nsum), .out_valid(mac_v), .out_h(mac_h));

  always_ff @(posedge clk) begin
    wa_q[0] <= ctr_a;
    wa_q[1] <= wa_q[0];
    if (state_r == S_STEP && cnt_r != 0 && cnt_r <= CW'(CELLS)) begin
      tap_r[0]  <= rd_cur;
      prvd_r[0] <= rd_prv;
      for (int i = 1; i < TAPS; i++) tap_r[i] <= tap_r[i-1];
      for (int i = 1; i <= GRID_COLS; i++) prvd_r[i] <= prvd_r[i-1];
    end else if (state_r == S_STEP) begin
      tap_r[0] <= 16'sd0;
      for (int i = 1; i < TAPS; i++) tap_r[i] <= tap_r[i-1];
      for (int i = 1; i <= GRID_COLS; i++) prvd_r[i] <= prvd_r[i-1];
    end
  end

  // disturb sequencing: five cells, each read, then written saturated
  logic [2:0]         dk_r;
  logic               dph_r;
  logic [AW-1:0]      daddr;
  logic [AW-1:0]      dcen;
  logic signed [15:0] dadd;
  assign dcen = AW'(row_r * GRID_COLS) + AW'(col_r);
  always_comb begin
    case (dk_r)
      3'd0: daddr = dcen;
      3'd1: daddr = dcen + AW'(1);
      3'd2: daddr = dcen - AW'(1);
      3'd3: daddr = dcen + AW'(GRID_COLS);
      default: daddr = dcen - AW'(GRID_COLS);
    endcase
  end
  assign dadd = (dk_r == 3'd0) ? mag_r : (mag_r >>> 1);

  always_comb begin
    rd_addr = '0;
    we0 = 1'b0;
    we1 = 1'b0;
    wa  = '0;
    wd  = '0;
    case (state_r)
      S_CLEAR: begin
        we0 = 1'b1;
        we1 = 1'b1;
        wa  = cnt_r[AW-1:0];
      end
      S_READ: rd_addr = AW'(row_r * GRID_COLS) + AW'(col_r);
      S_DIST: begin
        rd_addr = daddr;
        if (dph_r) begin
          wa = daddr;
          wd = weq_pkg::sat16(40'(rd_cur) + 40'(dadd));
          we0 = !sel_r;
          we1 = sel_r;
        end
      end
      S_STEP: begin
        rd_addr = cnt_r[AW-1:0];
        if (mac_v) begin
          wa = wa_q[1];
          wd = mac_h;
          we0 = sel_r;
          we1 = !sel_r;
        end
      end
      default: ;
    endcase
  end

  logic        rd_ok, dist_ok;
  logic [20:0] acc_sum;
  assign rd_ok   = in_tdata[22:16] < 7'(GRID_ROWS > 127 ? 127 : GRID_ROWS) ||
                   GRID_ROWS > 127;
  assign acc_sum = accum_r + 21'(in_tdata[15:0]);
  always_comb begin
    dist_ok = 32'(in_tdata[22:16]) > 1 && 32'(in_tdata[22:16]) < GRID_ROWS - 2 &&
              32'(in_tdata[29:23]) > 1 && 32'(in_tdata[29:23]) < GRID_COLS - 2;
  end

  assign in_tready = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_tvalid = state_r == S_OUT;
  assign out_tdata  = height_r;
  assign out_tuser  = {rerr_r, stepped_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cnt_r     <= '0;
      accum_r   <= '0;
      sel_r     <= 1'b0;
      coef_r    <= '{weq_pkg::COEF_PREV_RST, weq_pkg::COEF_CURR_RST,
                     weq_pkg::COEF_NEIGH_RST};
      period_r  <= weq_pkg::STEP_PERIOD_RST;
      tapv_r    <= 1'b0;
      rcnt_r    <= '0;
      crow_r    <= '0;
      ccol_r    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          weq_pkg::REG_COEF_PREV:   coef_r.coef_prev  <= cfg_data[15:0];
          weq_pkg::REG_COEF_CURR:   coef_r.coef_curr  <= cfg_data[15:0];
          weq_pkg::REG_COEF_NEIGH:  coef_r.coef_neigh <= cfg_data[15:0];
          weq_pkg::REG_STEP_PERIOD: period_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(CELLS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          row_r     <= in_tdata[22:16];
          col_r     <= in_tdata[29:23];
          mag_r     <= in_tdata[45:30];
          height_r  <= '0;
          stepped_r <= 1'b0;
          rerr_r    <= 1'b0;
          cnt_r     <= '0;
          dk_r      <= '0;
          dph_r     <= 1'b0;
          state_r   <= S_OUT;
          case (in_tuser)
            weq_pkg::MODE_TICK: begin
              if (acc_sum >= 21'(period_r)) begin
                accum_r   <= '0;
                stepped_r <= 1'b1;
                rcnt_r    <= '0;
                crow_r    <= '0;
                ccol_r    <= '0;
                tapv_r    <= 1'b0;
                state_r   <= S_STEP;
              end else accum_r <= acc_sum;
            end
            weq_pkg::MODE_DISTURB: begin
              if (dist_ok) state_r <= S_DIST;
              else rerr_r <= 1'b1;
            end
            weq_pkg::MODE_READ: begin
              if (rd_ok && (32'(in_tdata[29:23]) < GRID_COLS)) state_r <= S_READ;
            end
            default: ;
          endcase
        end
        S_READ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(1)) begin
            height_r <= rd_cur;
            state_r  <= S_OUT;
          end
        end
        S_DIST: begin
          dph_r <= !dph_r;
          if (dph_r) begin
            dk_r <= dk_r + 1'b1;
            if (dk_r == 3'd4) state_r <= S_OUT;
          end
        end
        S_STEP: begin
          cnt_r  <= cnt_r + 1'b1;
          tapv_r <= cnt_r != 0;
          if (cnt_r != 0) begin
            rcnt_r <= rcnt_r + 1'b1;
            // center moves on once it has entered the grid
            if (rcnt_r >= CW'(GRID_COLS + 1)) begin
              if (ccol_r == CLW'(GRID_COLS - 1)) begin
                ccol_r <= '0;
                crow_r <= crow_r + 1'b1;
              end else begin
                ccol_r <= ccol_r + 1'b1;
              end
            end
          end
          if (cnt_r == CW'(CELLS + GRID_COLS + 6)) begin
            sel_r   <= !sel_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !we0 && !we1) else $error("bank write while idle");

endmodule

### rtl/weq_mac.sv
// pipelined update arithmetic: three products, sum, round and saturate
module weq_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  weq_pkg::coef_t     coef,
  input  logic signed [15:0] prev_h,
  input  logic signed [15:0] curr_h,
  input  logic signed [17:0] nsum,
  output logic               out_valid,
  output logic signed [15:0] out_h
);

  logic               v1_r, v2_r;
  logic signed [31:0] p0_r, p1_r;
  logic signed [33:0] p2_r;
  logic signed [15:0] h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    p0_r <= coef.coef_prev * prev_h;
    p1_r <= coef.coef_curr * curr_h;
    p2_r <= coef.coef_neigh * nsum;
    // arithmetic shift gives floor, bias gives round half up
    h_r  <= weq_pkg::sat16(40'((40'(p0_r) + 40'(p1_r) + 40'(p2_r) + 40'sd8192) >>> 14));
  end

  assign out_valid = v2_r;
  assign out_h     = h_r;

endmodule

### rtl/weq_bank.sv
// one height bank: synchronous ram with one read and one write port
module weq_bank #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic               clk,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [15:0] rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [15:0] wr_data
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

### test/tb_wave_equation_grid_step.sv
// testbench for the wave equation grid block: directed table, random traffic, predictor check
`timescale 1ns / 100ps

module tb_wave_equation_grid_step;

  localparam int ROWS = 128;
  localparam int COLS = 128;
  localparam int CELLS = ROWS * COLS;
  localparam longint CYCLE_LIMIT = 64'd12_000_000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        delta_time;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] magnitude;
  } word_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               stepped;
    logic               range_error;
  } result_t;

  typedef struct {
    word_t   w;
    bit      known;
    result_t r;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  wave_equation_grid_step i_dut (.*);

  // predictor state
  logic signed [15:0] bank_q[2][CELLS];
  logic signed [15:0] w_prev, w_curr, w_neigh;
  logic [19:0]        period_q;
  logic [20:0]        accum_q;
  bit                 sel_q;

  result_t heights_due[$];
  int      mismatches;
  int      sender_idle_pct;
  int      receiver_stall_pct;
  int      hold_off_cycles;
  longint  cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic step_grid();
    bit cs;
    int idx;
    longint acc;
    longint nsum;
    cs = sel_q;
    for (int r = 1; r < ROWS - 1; r++) begin
      for (int c = 1; c < COLS - 1; c++) begin
        idx = r * COLS + c;
        nsum = longint'(bank_q[cs][idx - COLS]) + bank_q[cs][idx + COLS]
             + bank_q[cs][idx - 1] + bank_q[cs][idx + 1];
        acc = longint'(w_prev) * bank_q[!cs][idx] + longint'(w_curr) * bank_q[cs][idx]
            + longint'(w_neigh) * nsum + 8192;
        bank_q[!cs][idx] = clip16(acc >>> 14);
      end
    end
    sel_q = !sel_q;
  endtask

  function automatic void bump(int idx, int amount);
    bank_q[sel_q][idx] = clip16(longint'(bank_q[sel_q][idx]) + amount);
  endfunction

  task automatic predict_word(input word_t w, output result_t r);
    int idx;
    int half;
    r = '0;
    case (w.mode)
      weq_pkg::MODE_TICK: begin
        accum_q = accum_q + w.delta_time;
        if (accum_q >= {1'b0, period_q}) begin
          step_grid();
          accum_q = '0;
          r.stepped = 1'b1;
        end
      end
      weq_pkg::MODE_DISTURB: begin
        if (w.row > 1 && w.row < ROWS - 2 && w.col > 1 && w.col < COLS - 2) begin
          idx = w.row * COLS + w.col;
          half = int'(w.magnitude) >>> 1;
          bump(idx, w.magnitude);
          bump(idx + 1, half);
          bump(idx - 1, half);
          bump(idx + COLS, half);
          bump(idx - COLS, half);
        end else begin
          r.range_error = 1'b1;
        end
      end
      weq_pkg::MODE_READ: r.height = bank_q[sel_q][w.row * COLS + w.col];
      default: ;
    endcase
  endtask

  task automatic send_word(input word_t w, input bit known, input result_t typed);
    result_t r;
    in_tdata <= {2'b00, w.magnitude, w.col, w.row, w.delta_time};
    in_tuser <= w.mode;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_word(w, r);
    if (known && r != typed)
      $display("directed row disagrees with predictor: %h vs %h", typed, r);
    heights_due.push_back(known ? typed : r);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [19:0] value);
    @(negedge clk);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      weq_pkg::REG_COEF_PREV:   w_prev = value[15:0];
      weq_pkg::REG_COEF_CURR:   w_curr = value[15:0];
      weq_pkg::REG_COEF_NEIGH:  w_neigh = value[15:0];
      weq_pkg::REG_STEP_PERIOD: period_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (heights_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic word_t rand_word(bit shaped);
    word_t w;
    int pick;
    w.delta_time = 16'($urandom_range(65535));
    w.row = 7'($urandom_range(127));
    w.col = 7'($urandom_range(127));
    w.magnitude = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 12) w.mode = weq_pkg::MODE_TICK;
    else if (pick < 55) w.mode = weq_pkg::MODE_DISTURB;
    else if (pick < 97) w.mode = weq_pkg::MODE_READ;
    else w.mode = MODE_UNUSED;
    // keep most addresses near disturbed cells and ticks mostly short
    if (shaped && $urandom_range(3) != 0) begin
      w.row = 7'($urandom_range(60, 66));
      w.col = 7'($urandom_range(60, 66));
      if (w.mode == weq_pkg::MODE_TICK) w.delta_time = 16'($urandom_range(8000));
    end
    return w;
  endfunction

  // receiver with random stall and one long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_wave_equation_grid_step: FAIL");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser[0], out_tuser[1]};
      if (heights_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = heights_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: height exp %0d got %0d, stepped exp %b got %b, ",
                      "range_error exp %b got %b"},
                     want.height, got.height, want.stepped, got.stepped,
                     want.range_error, got.range_error);
        end
      end
    end
  end

  initial begin
    dir_row_t tbl[$];
    dir_row_t e;
    word_t w;
    clk = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    foreach (bank_q[b, i]) bank_q[b][i] = '0;
    w_prev = weq_pkg::COEF_PREV_RST;
    w_curr = weq_pkg::COEF_CURR_RST;
    w_neigh = weq_pkg::COEF_NEIGH_RST;
    period_q = weq_pkg::STEP_PERIOD_RST;
    accum_q = '0;
    sel_q = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: read after reset, border disturbs, extremes, unused mode, step
    tbl = '{
      '{'{weq_pkg::MODE_READ, 16'd0, 7'd64, 7'd64, 16'sd0}, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_READ, 16'hffff, 7'd127, 7'd127, -16'sd1}, 1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_DISTURB, 16'd0, 7'd1, 7'd64, 16'sd100}, 1'b1,
        '{16'sd0, 1'b0, 1'b1}},
      '{'{weq_pkg::MODE_DISTURB, 16'd0, 7'd64, 7'd126, 16'sd100}, 1'b1,
        '{16'sd0, 1'b0, 1'b1}},
      '{'{weq_pkg::MODE_DISTURB, 16'd0, 7'd127, 7'd0, 16'sd100}, 1'b1,
        '{16'sd0, 1'b0, 1'b1}},
      '{'{weq_pkg::MODE_DISTURB, 16'd0, 7'd2, 7'd2, 16'sh7fff}, 1'b0,
        '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_DISTURB, 16'd0, 7'd125, 7'd125, 16'sh8000}, 1'b0,
        '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_DISTURB, 16'd0, 7'd2, 7'd2, 16'sh7fff}, 1'b0,
        '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_READ, 16'd0, 7'd2, 7'd2, 16'sd0}, 1'b1, '{16'sh7fff, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_READ, 16'd0, 7'd125, 7'd125, 16'sd0}, 1'b1,
        '{16'sh8000, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_DISTURB, 16'd0, 7'd64, 7'd64, -16'sd3}, 1'b0,
        '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_READ, 16'd0, 7'd64, 7'd65, 16'sd0}, 1'b1, '{-16'sd2, 1'b0, 1'b0}},
      '{'{MODE_UNUSED, 16'hffff, 7'd64, 7'd64, 16'sh7fff}, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_TICK, 16'd29999, 7'd0, 7'd0, 16'sd0}, 1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_TICK, 16'd1, 7'd0, 7'd0, 16'sd0}, 1'b1, '{16'sd0, 1'b1, 1'b0}},
      '{'{weq_pkg::MODE_READ, 16'd0, 7'd64, 7'd64, 16'sd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
      '{'{weq_pkg::MODE_READ, 16'd0, 7'd3, 7'd2, 16'sd0}, 1'b0, '{16'sd0, 1'b0, 1'b0}}
    };
    foreach (tbl[i]) begin
      e = tbl[i];
      send_word(e.w, e.known, e.r);
    end
    drain();

    // random phases under several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(weq_pkg::REG_STEP_PERIOD, 20'd0);
          write_reg(weq_pkg::REG_COEF_PREV, 20'h08000);
          write_reg(weq_pkg::REG_COEF_CURR, 20'h07fff);
          write_reg(weq_pkg::REG_COEF_NEIGH, 20'h07fff);
        end
        1: begin
          write_reg(weq_pkg::REG_STEP_PERIOD, 20'd1000000);
          sender_idle_pct = 79;
        end
        2: begin
          write_reg(weq_pkg::REG_STEP_PERIOD, 20'd1);
          write_reg(weq_pkg::REG_COEF_PREV, 20'h0c062);
          write_reg(weq_pkg::REG_COEF_CURR, 20'h07bf1);
          write_reg(weq_pkg::REG_COEF_NEIGH, 20'h000eb);
          sender_idle_pct = 0;
          receiver_stall_pct = 79;
        end
        3: begin
          write_reg(weq_pkg::REG_STEP_PERIOD, 20'd10000);
          sender_idle_pct = 23;
          receiver_stall_pct = 23;
        end
        default: begin
          write_reg(weq_pkg::REG_STEP_PERIOD, 20'($urandom_range(1, 20000)));
          write_reg(weq_pkg::REG_COEF_NEIGH, 20'($urandom_range(65535)));
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          @(negedge clk);
          hold_off_cycles <= 300;
        end
      endcase
      for (int n = 0; n < 20; n++) begin
        w = rand_word($urandom_range(4) != 0);
        // the huge-period phase needs big ticks to reach the period at all
        if (ph == 1 && w.mode == weq_pkg::MODE_TICK) w.delta_time = 16'hffff;
        send_word(w, 1'b0, '0);
      end
      drain();
    end

    repeat (100) @(negedge clk);
    if (mismatches == 0 && heights_due.size() == 0) begin
      $display("tb_wave_equation_grid_step: PASS");
    end else begin
      $display("tb_wave_equation_grid_step: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/weq_pkg.sv
rtl/weq_mac.sv
rtl/weq_bank.sv
rtl/wave_equation_grid_step.sv
test/tb_wave_equation_grid_step.sv
